// ===== rtl/core/eda_pkg.sv =====
package eda_pkg;

  localparam int unsigned DataW       = 24;
  localparam int unsigned AccW        = 48;
  localparam int unsigned IdxW        = 16;
  localparam int unsigned MaxExcitons = 65536;
  localparam int unsigned OpW         = 30;
  localparam int unsigned ProdW       = 2 * OpW;
  localparam int unsigned FracW       = 20;

  // Reciprocal of three scaled by 2^30 and rounded up; exact for operands below 2^29.
  localparam logic signed [OpW-1:0] RecipThird = 30'sd357913942;

  localparam logic [1:0] AxisNone = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ITEM  = 7'b0000010,
    S_NORM  = 7'b0000100,
    S_SQRT  = 7'b0001000,
    S_STREN = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_LOAD  = 7'b1000000
  } state_e;

  // Adds a signed term to an accumulator and clamps to the accumulator range.
  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64:AccW-1] == '0 || s[64:AccW-1] == '1) begin
      return s[AccW-1:0];
    end else if (s[64]) begin
      return {1'b1, {(AccW-1){1'b0}}};
    end else begin
      return {1'b0, {(AccW-1){1'b1}}};
    end
  endfunction

  // Brings a Q.40 value to Q.20, rounding half up.
  function automatic logic signed [40:0] rnd20(input logic signed [60:0] x);
    logic signed [60:0] y;
    y = x + 61'sd524288;
    return y[60:FracW];
  endfunction

endpackage

// ===== rtl/core/eda_mul.sv =====
module eda_mul (
  input  logic                                 clk_i,
  input  logic signed [eda_pkg::OpW-1:0]       a_i,
  input  logic signed [eda_pkg::OpW-1:0]       b_i,
  output logic signed [eda_pkg::ProdW-1:0]     prod_o
);

  logic signed [eda_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= eda_pkg::ProdW'(a_i) * eda_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/exciton_dipole_accumulator.sv =====
// Exciton dipole accumulator.
// The input channel takes one transaction per Cartesian axis of one electron-hole
// pair: the complex coefficient, the complex electric and magnetic dipole
// components, the exciton energy and a flag that closes the exciton. Every
// product goes through one shared registered multiplier under a small sequencer.
// An ordinary item runs 13 multiplications while the input is not ready, so
// the block takes no new item until it is through with the last; an item on
// axis three adds no products. The item that closes an exciton further runs
// the norms (three partial products per sum), two bit-serial square roots and
// two strengths, each two multiplications followed by a division by three
// through two reciprocal multiplications, and a load step that offers the result.
// The output channel holds its result in a register until the transaction
// completes; the block keeps accepting items meanwhile, but a later closing item
// waits in its load step, input not ready, until the earlier result is taken.
// Reset clears all sums, the exciton index and the output valid flag.
module exciton_dipole_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    axis_i,
  input  logic signed [23:0]            coeff_re_i,
  input  logic signed [23:0]            coeff_im_i,
  input  logic signed [23:0]            elec_re_i,
  input  logic signed [23:0]            elec_im_i,
  input  logic signed [23:0]            magn_re_i,
  input  logic signed [23:0]            magn_im_i,
  input  logic [23:0]                   energy_i,
  input  logic                          last_of_exciton_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   exciton_index_o,
  output logic [47:0]                   elec_norm_sq_o,
  output logic [23:0]                   elec_magnitude_o,
  output logic [47:0]                   osc_strength_o,
  output logic [47:0]                   magn_norm_sq_o,
  output logic [23:0]                   magn_magnitude_o,
  output logic [47:0]                   magn_strength_o,
  output logic signed [47:0]            rot_strength_o
);

  localparam int unsigned AccW = eda_pkg::AccW;
  localparam int unsigned OpW  = eda_pkg::OpW;

  eda_pkg::state_e state_q;
  logic [5:0]  cnt_q;
  logic [3:0]  ent_q;
  logic        sel_q;

  logic [1:0]         axis_q;
  logic signed [23:0] cr_q, ci_q, er_q, ei_q, mr_q, mi_q;
  logic [23:0]        e_q;
  logic               last_q;

  logic signed [AccW-1:0] sums_q [12];
  logic signed [AccW-1:0] rot_q;
  logic [eda_pkg::IdxW-1:0] exc_q;

  logic signed [60:0] pa_q;
  logic signed [28:0] c2_q, ri_q;
  logic [67:0] sq_acc_q;
  logic [47:0] en_q, mn_q;
  logic [23:0] emag_q, mmag_q;
  logic [47:0] sx_q, sres_q, bit_q;
  logic [52:0] ta_q;
  logic [53:0] dv_q;
  logic [25:0] quo_q;
  logic [1:0]  rem_q;
  logic [47:0] eosc_q, mstr_q;

  logic        out_valid_q;
  logic [15:0] o_idx_q;
  logic [47:0] o_en_q, o_eosc_q, o_mn_q, o_mstr_q;
  logic [23:0] o_emag_q, o_mmag_q;
  logic signed [47:0] o_rot_q;

  logic signed [OpW-1:0] mul_a, mul_b;
  logic signed [eda_pkg::ProdW-1:0] prod;

  logic [3:0]          pidx;
  logic                neg;
  logic signed [60:0]  term, total;
  logic signed [40:0]  rv;
  logic [2:0]          dest;
  logic [3:0]          sidx;
  logic [47:0]         mabs;
  logic                mbig;
  logic [16:0]         ma, mb;
  logic [47:0]         sqv, sq;
  logic [48:0]         nsum;
  logic [47:0]         nv;
  logic [47:0]         ssum;
  logic [52:0]         tv;
  logic [47:0]         sv;
  logic [16:0]         nx;

  eda_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    pidx  = 4'(cnt_q - 6'd1);
    neg   = (pidx == 4'd1) || (pidx == 4'd5) || (pidx == 4'd11);
    term  = neg ? -61'(prod) : 61'(prod);
    total = pa_q + term;
    rv    = eda_pkg::rnd20(total);
    dest  = pidx[3:1];
    sidx  = (dest[1] ? 4'd6 : 4'd0) + {1'b0, axis_q, 1'b0} + {3'b000, dest[0]};
    mabs  = sums_q[ent_q][AccW-1] ? 48'(-sums_q[ent_q]) : 48'(sums_q[ent_q]);
    mbig  = |mabs[47:34];
    ma    = mabs[33:17];
    mb    = mabs[16:0];
    sqv   = 48'((sq_acc_q + 68'd524288) >> 20);
    sq    = mbig ? '1 : sqv;
    nsum  = {1'b0, (ent_q < 4'd6) ? en_q : mn_q} + {1'b0, sq};
    nv    = sel_q ? mn_q : en_q;
    ssum  = sres_q + bit_q;
    tv    = ta_q + 53'(prod[47:20]);
    sv    = (|quo_q[25:21]) ? '1 : {quo_q[20:0], prod[56:30]};
    nx    = 17'(exc_q) + 17'd1;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      eda_pkg::S_ITEM: begin
        case (cnt_q)
          6'd0:  begin mul_a = OpW'(cr_q); mul_b = OpW'(er_q); end
          6'd1:  begin mul_a = OpW'(ci_q); mul_b = OpW'(ei_q); end
          6'd2:  begin mul_a = OpW'(cr_q); mul_b = OpW'(ei_q); end
          6'd3:  begin mul_a = OpW'(ci_q); mul_b = OpW'(er_q); end
          6'd4:  begin mul_a = OpW'(cr_q); mul_b = OpW'(mr_q); end
          6'd5:  begin mul_a = OpW'(ci_q); mul_b = OpW'(mi_q); end
          6'd6:  begin mul_a = OpW'(cr_q); mul_b = OpW'(mi_q); end
          6'd7:  begin mul_a = OpW'(ci_q); mul_b = OpW'(mr_q); end
          6'd8:  begin mul_a = OpW'(cr_q); mul_b = OpW'(cr_q); end
          6'd9:  begin mul_a = OpW'(ci_q); mul_b = OpW'(ci_q); end
          6'd10: begin mul_a = OpW'(ei_q); mul_b = OpW'(mr_q); end
          6'd11: begin mul_a = OpW'(er_q); mul_b = OpW'(mi_q); end
          default: begin mul_a = OpW'(c2_q); mul_b = OpW'(ri_q); end
        endcase
      end
      eda_pkg::S_NORM: begin
        case (cnt_q)
          6'd0:    begin mul_a = OpW'(ma); mul_b = OpW'(ma); end
          6'd1:    begin mul_a = OpW'(ma); mul_b = OpW'(mb); end
          default: begin mul_a = OpW'(mb); mul_b = OpW'(mb); end
        endcase
      end
      eda_pkg::S_STREN: begin
        mul_a = OpW'(e_q);
        mul_b = (cnt_q == 6'd0) ? OpW'(nv[47:24]) : OpW'(nv[23:0]);
      end
      eda_pkg::S_DIV: begin
        mul_a = (cnt_q == 6'd0) ? OpW'(dv_q[53:27]) : OpW'({rem_q, dv_q[26:0]});
        mul_b = eda_pkg::RecipThird;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eda_pkg::S_IDLE;
      cnt_q       <= '0;
      ent_q       <= '0;
      sel_q       <= 1'b0;
      for (int k = 0; k < 12; k++) begin
        sums_q[k] <= '0;
      end
      rot_q       <= '0;
      exc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != eda_pkg::S_LOAD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        eda_pkg::S_IDLE: begin
          if (in_valid_i) begin
            axis_q <= axis_i;
            cr_q   <= coeff_re_i;
            ci_q   <= coeff_im_i;
            er_q   <= elec_re_i;
            ei_q   <= elec_im_i;
            mr_q   <= magn_re_i;
            mi_q   <= magn_im_i;
            e_q    <= energy_i;
            last_q <= last_of_exciton_i;
            en_q   <= '0;
            mn_q   <= '0;
            cnt_q  <= '0;
            ent_q  <= '0;
            sel_q  <= 1'b0;
            if (axis_i != eda_pkg::AxisNone) begin
              state_q <= eda_pkg::S_ITEM;
            end else if (last_of_exciton_i) begin
              state_q <= eda_pkg::S_NORM;
            end
          end
        end
        eda_pkg::S_ITEM: begin
          if (cnt_q >= 6'd1 && cnt_q <= 6'd12) begin
            if (!pidx[0]) begin
              pa_q <= term;
            end else begin
              case (dest)
                3'd4:    c2_q <= rv[28:0];
                3'd5:    ri_q <= rv[28:0];
                default: sums_q[sidx] <= eda_pkg::sat_add(sums_q[sidx], 64'(rv));
              endcase
            end
          end
          if (cnt_q == 6'd14) begin
            rot_q   <= eda_pkg::sat_add(rot_q, 64'(eda_pkg::rnd20(61'(prod))));
            cnt_q   <= '0;
            state_q <= last_q ? eda_pkg::S_NORM : eda_pkg::S_IDLE;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        eda_pkg::S_NORM: begin
          if (cnt_q == 6'd4) begin
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
          case (cnt_q)
            6'd1: sq_acc_q <= {prod[33:0], 34'd0};
            6'd2: sq_acc_q <= sq_acc_q + {16'd0, prod[33:0], 18'd0};
            6'd3: sq_acc_q <= sq_acc_q + 68'(prod[33:0]);
            6'd4: begin
              if (ent_q < 4'd6) begin
                en_q <= nsum[48] ? '1 : nsum[47:0];
              end else begin
                mn_q <= nsum[48] ? '1 : nsum[47:0];
              end
              if (ent_q == 4'd11) begin
                ent_q   <= '0;
                sel_q   <= 1'b0;
                state_q <= eda_pkg::S_SQRT;
              end else begin
                ent_q <= ent_q + 4'd1;
              end
            end
            default: ;
          endcase
        end
        eda_pkg::S_SQRT: begin
          if (cnt_q == 6'd0) begin
            cnt_q  <= cnt_q + 6'd1;
            sx_q   <= {nv[27:0], 20'd0};
            sres_q <= '0;
            bit_q  <= 48'd1 << 46;
          end else if (cnt_q <= 6'd24) begin
            cnt_q <= cnt_q + 6'd1;
            if (sx_q >= ssum) begin
              sx_q   <= sx_q - ssum;
              sres_q <= (sres_q >> 1) + bit_q;
            end else begin
              sres_q <= sres_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            cnt_q <= '0;
            if (!sel_q) begin
              emag_q <= (|nv[47:28]) ? '1 : sres_q[23:0];
              sel_q  <= 1'b1;
            end else begin
              mmag_q  <= (|nv[47:28]) ? '1 : sres_q[23:0];
              sel_q   <= 1'b0;
              state_q <= eda_pkg::S_STREN;
            end
          end
        end
        eda_pkg::S_STREN: begin
          if (cnt_q == 6'd1) begin
            ta_q <= 53'({prod[47:0], 4'd0});
          end
          if (cnt_q == 6'd2) begin
            dv_q    <= sel_q ? 54'({tv, 2'd0}) : 54'({tv, 1'd0});
            quo_q   <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= eda_pkg::S_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        eda_pkg::S_DIV: begin
          if (cnt_q == 6'd3) begin
            cnt_q <= '0;
            if (!sel_q) begin
              eosc_q  <= sv;
              sel_q   <= 1'b1;
              state_q <= eda_pkg::S_STREN;
            end else begin
              mstr_q  <= sv;
              sel_q   <= 1'b0;
              state_q <= eda_pkg::S_LOAD;
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd1) begin
              quo_q <= prod[55:30];
              rem_q <= dv_q[28:27] - prod[31:30] - {prod[30], 1'b0};
            end
          end
        end
        eda_pkg::S_LOAD: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_idx_q     <= exc_q;
            o_en_q      <= en_q;
            o_emag_q    <= emag_q;
            o_eosc_q    <= eosc_q;
            o_mn_q      <= mn_q;
            o_mmag_q    <= mmag_q;
            o_mstr_q    <= mstr_q;
            o_rot_q     <= rot_q;
            for (int k = 0; k < 12; k++) begin
              sums_q[k] <= '0;
            end
            rot_q <= '0;
            if (32'(nx) >= 32'(eda_pkg::MaxExcitons)) begin
              exc_q <= '0;
            end else begin
              exc_q <= nx[15:0];
            end
            state_q <= eda_pkg::S_IDLE;
          end
        end
        default: state_q <= eda_pkg::S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == eda_pkg::S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign exciton_index_o  = o_idx_q;
  assign elec_norm_sq_o   = o_en_q;
  assign elec_magnitude_o = o_emag_q;
  assign osc_strength_o   = o_eosc_q;
  assign magn_norm_sq_o   = o_mn_q;
  assign magn_magnitude_o = o_mmag_q;
  assign magn_strength_o  = o_mstr_q;
  assign rot_strength_o   = o_rot_q;

endmodule

// ===== rtl/core/eda_checker.sv =====
module eda_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        exciton_index_o,
  input logic [47:0]        elec_norm_sq_o,
  input logic [23:0]        elec_magnitude_o,
  input logic [47:0]        osc_strength_o,
  input logic [47:0]        magn_norm_sq_o,
  input logic [23:0]        magn_magnitude_o,
  input logic [47:0]        magn_strength_o,
  input logic signed [47:0] rot_strength_o
);

  // A stalled result transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(exciton_index_o) && $stable(rot_strength_o)
      && $stable(osc_strength_o))
    else $error("result changed while stalled");

  // A waiting input transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input withdrawn while waiting");

  // The electric magnitude never overshoots the square root of the norm while the norm is below 2^28.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (elec_norm_sq_o[47:28] == 20'd0) |->
      (48'(elec_magnitude_o) * 48'(elec_magnitude_o) <= {elec_norm_sq_o[27:0], 20'd0}))
    else $error("electric magnitude too large");

  // A vanishing magnetic norm gives a vanishing magnetic strength and magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (magn_norm_sq_o == 48'd0) |->
      (magn_strength_o == 48'd0) && (magn_magnitude_o == 24'd0))
    else $error("magnetic strength without norm");

endmodule

bind exciton_dipole_accumulator eda_checker u_eda_checker (.*);

// ===== dv/tb_exciton_dipole_accumulator.sv =====
`timescale 1ns / 1ps

module tb_exciton_dipole_accumulator;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [23:0] coeff_re;
    logic signed [23:0] coeff_im;
    logic signed [23:0] elec_re;
    logic signed [23:0] elec_im;
    logic signed [23:0] magn_re;
    logic signed [23:0] magn_im;
    logic [23:0]        energy;
    logic               last;
  } pair_axis_t;

  typedef struct packed {
    logic [15:0]        index;
    logic [47:0]        elec_norm;
    logic [23:0]        elec_mag;
    logic [47:0]        osc;
    logic [47:0]        magn_norm;
    logic [23:0]        magn_mag;
    logic [47:0]        magn_str;
    logic signed [47:0] rot;
  } exciton_res_t;

  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisZ = 2'd2;

  class dipole_scoreboard;
    longint       elec_acc[6];
    longint       magn_acc[6];
    longint       rot_acc;
    logic [15:0]  count;
    exciton_res_t pending[$];
    int           errors;

    function void clear_sums();
      for (int k = 0; k < 6; k++) begin
        elec_acc[k] = 0;
        magn_acc[k] = 0;
      end
      rot_acc = 0;
    endfunction

    function longint q20(longint x);
      return (x + 64'sd524288) >>> 20;
    endfunction

    function longint sat(longint a, longint b);
      longint s;
      s = a + b;
      if (s > AccMax) return AccMax;
      if (s < AccMin) return AccMin;
      return s;
    endfunction

    function logic [47:0] norm6(longint s[6]);
      logic [127:0] m, v, t;
      t = 0;
      for (int k = 0; k < 6; k++) begin
        m = (s[k] < 0) ? 128'(-s[k]) : 128'(s[k]);
        v = (m * m + 128'd524288) >> 20;
        if (v > 128'hFFFF_FFFF_FFFF) v = 128'hFFFF_FFFF_FFFF;
        t = t + v;
      end
      if (t > 128'hFFFF_FFFF_FFFF) t = 128'hFFFF_FFFF_FFFF;
      return t[47:0];
    endfunction

    function logic [23:0] root(logic [47:0] n);
      logic [63:0] x, r, c;
      if (n >= 48'd268435456) return 24'hFFFFFF;
      x = {16'd0, n} << 20;
      r = 0;
      for (int b = 23; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= x) r = c;
      end
      return r[23:0];
    endfunction

    function logic [47:0] stren(logic [23:0] e, logic [47:0] n, int k);
      logic [127:0] t;
      t = (128'(e) * 128'(n)) >> 20;
      t = (t * k) / 3;
      if (t > 128'hFFFF_FFFF_FFFF) t = 128'hFFFF_FFFF_FFFF;
      return t[47:0];
    endfunction

    function void note(pair_axis_t it);
      longint cr, ci, er, ei, mr, mi, c2, ri;
      int i;
      exciton_res_t r;
      cr = it.coeff_re; ci = it.coeff_im;
      er = it.elec_re;  ei = it.elec_im;
      mr = it.magn_re;  mi = it.magn_im;
      if (it.axis <= AxisZ) begin
        i = int'(it.axis) * 2;
        elec_acc[i]   = sat(elec_acc[i],   q20(cr * er - ci * ei));
        elec_acc[i+1] = sat(elec_acc[i+1], q20(cr * ei + ci * er));
        magn_acc[i]   = sat(magn_acc[i],   q20(cr * mr - ci * mi));
        magn_acc[i+1] = sat(magn_acc[i+1], q20(cr * mi + ci * mr));
        c2 = q20(cr * cr + ci * ci);
        ri = q20(ei * mr - er * mi);
        rot_acc = sat(rot_acc, q20(c2 * ri));
      end
      if (!it.last) return;
      r.index     = count;
      r.elec_norm = norm6(elec_acc);
      r.elec_mag  = root(r.elec_norm);
      r.osc       = stren(it.energy, r.elec_norm, 2);
      r.magn_norm = norm6(magn_acc);
      r.magn_mag  = root(r.magn_norm);
      r.magn_str  = stren(it.energy, r.magn_norm, 4);
      r.rot       = rot_acc[47:0];
      pending.push_back(r);
      clear_sums();
      count++;
    endfunction

    function void check(exciton_res_t act);
      exciton_res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result transaction: %p", act);
        return;
      end
      exp_r = pending.pop_front();
      if (act !== exp_r) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %p, actual %p", exp_r, act);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, last_of_exciton_i, out_valid_o, out_ready_i;
  logic [1:0] axis_i;
  logic signed [23:0] coeff_re_i, coeff_im_i, elec_re_i, elec_im_i, magn_re_i, magn_im_i;
  logic [23:0] energy_i;
  logic [15:0] exciton_index_o;
  logic [47:0] elec_norm_sq_o, osc_strength_o, magn_norm_sq_o, magn_strength_o;
  logic [23:0] elec_magnitude_o, magn_magnitude_o;
  logic signed [47:0] rot_strength_o;

  exciton_dipole_accumulator dut (.*);

  dipole_scoreboard sb;
  int  send_idle_pct, recv_stall_pct, accepted;
  longint cycles = 0;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd6000000) begin
      $display("exciton_dipole_accumulator test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note({axis_i, coeff_re_i, coeff_im_i, elec_re_i, elec_im_i, magn_re_i,
               magn_im_i, energy_i, last_of_exciton_i});
      accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check({exciton_index_o, elec_norm_sq_o, elec_magnitude_o, osc_strength_o,
                magn_norm_sq_o, magn_magnitude_o, magn_strength_o, rot_strength_o});
  end

  function automatic logic [23:0] pick_value();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h0;
      3, 4: return 24'($urandom);
      default: return 24'($signed($urandom_range(2097151)) - 1048576);
    endcase
  endfunction

  task automatic send(pair_axis_t it);
    in_valid_i <= 1'b1;
    {axis_i, coeff_re_i, coeff_im_i, elec_re_i, elec_im_i, magn_re_i, magn_im_i,
     energy_i, last_of_exciton_i} <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_random(logic [1:0] ax, logic last);
    pair_axis_t it;
    it.axis = ax;
    it.coeff_re = pick_value(); it.coeff_im = pick_value();
    it.elec_re  = pick_value(); it.elec_im  = pick_value();
    it.magn_re  = pick_value(); it.magn_im  = pick_value();
    it.energy   = ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom);
    it.last     = last;
    send(it);
  endtask

  task automatic send_exciton();
    int pairs;
    pairs = ($urandom_range(7) == 0) ? $urandom_range(8, 3) : $urandom_range(2, 1);
    for (int p = 0; p < pairs; p++)
      for (int a = 0; a < 3; a++)
        send_random(2'(a), (p == pairs - 1) && (a == 2));
  endtask

  initial begin
    pair_axis_t it;
    sb = new();
    sb.clear_sums();
    sb.count = 0;
    sb.errors = 0;
    accepted = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    {axis_i, coeff_re_i, coeff_im_i, elec_re_i, elec_im_i, magn_re_i, magn_im_i,
     energy_i, last_of_exciton_i} = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, a closing item on axis three, single-item excitons.
    for (int a = 0; a < 3; a++)
      send({2'(a), {6{24'sh7FFFFF}}, 24'hFFFFFF, a == 2});
    for (int a = 0; a < 3; a++)
      send({2'(a), {6{24'sh800000}}, 24'hFFFFFF, a == 2});
    send({AxisX, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
          24'sh800000, 24'h000000, 1'b1});
    send({AxisX, {6{24'sh0}}, 24'h0, 1'b1});
    send({2'd3, {6{24'sh7FFFFF}}, 24'hFFFFFF, 1'b1});
    send({2'd3, {6{24'sh123456}}, 24'h100000, 1'b0});
    send({AxisZ, 24'sh100000, 24'sh0, 24'sh100000, 24'sh0, 24'sh0, 24'sh100000,
          24'h100000, 1'b1});
    send({2'd1, 24'sh000001, 24'shFFFFFF, 24'sh080000, 24'shF80000, 24'sh000001,
          24'sh7FFFFF, 24'hFFFFFF, 1'b1});
    for (int k = 0; k < 5; k++) send_random(2'($urandom_range(3)), k == 4);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 81 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 28 : 0;
      while (accepted < 20 + (ph + 1) * 388) begin
        if ($urandom_range(9) < 8) send_exciton();
        else send_random(2'($urandom_range(3)), $urandom_range(3) == 0);
      end
    end
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("exciton_dipole_accumulator test passed");
    else
      $display("exciton_dipole_accumulator test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/eda_pkg.sv
rtl/core/eda_mul.sv
rtl/core/exciton_dipole_accumulator.sv
rtl/core/eda_checker.sv
dv/tb_exciton_dipole_accumulator.sv
